// File: rtl/spqd_pkg.sv
// Shared constants and types for the strict priority four queue dispatcher.
`default_nettype none
package spqd_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumClasses = 4;
  localparam int unsigned SlotW      = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned ClassW     = 2;
  localparam int unsigned IdW        = 16;
  localparam int unsigned SvcW       = 16;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } opcode_e;

  // One queued request.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [SvcW-1:0] svc;
  } request_t;

  // Token handed down the chain of class cells during a dispatch.
  typedef struct packed {
    logic              open;   // still searching for a non-empty class
    logic              hit;    // a cell upstream has given its head request
    logic [ClassW-1:0] cls;
    request_t          req;
  } pick_t;

endpackage
`default_nettype wire

// File: rtl/spqd_cell.sv
// One class cell: a circular queue of requests plus its stage of the priority chain.
`default_nettype none
module spqd_cell
  import spqd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ClassW-1:0] cell_cls_i,
  input  wire logic              push_i,
  input  wire request_t          push_req_i,
  input  wire pick_t             pick_i,
  output pick_t                  pick_o,
  output logic                   full_o
);

  request_t            mem_q [QueueDepth];
  logic [SlotW-1:0]    head_q, head_d;
  logic [SlotW-1:0]    tail_q, tail_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                empty;
  logic                take;
  logic                do_push;

  assign empty   = (count_q == '0);
  assign full_o  = (count_q == CountW'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign take    = pick_i.open && !empty;

  // Pass the token on, or claim it with the oldest request of this class.
  always_comb begin
    pick_o = pick_i;
    if (take) begin
      pick_o.open = 1'b0;
      pick_o.hit  = 1'b1;
      pick_o.cls  = cell_cls_i;
      pick_o.req  = mem_q[head_q];
    end
  end

  // Pointer and fill level updates; push and pop never meet in one cycle.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d  = (tail_q == SlotW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (take) begin
      head_d  = (head_q == SlotW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Request storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= push_req_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/strict_priority_four_queue_dispatch_top.sv
// Top level: class cells chained in priority order, server timer and output register.
// Each result word is registered from its input word when that word is accepted.
// Throughput: one word per cycle unless the receiver stalls; the single pass of the pick
// token down the cell chain, one push or pop and the server count all settle in that cycle.
// Reset: rst_ni clears queue pointers, fill levels, the server timer and the
// output valid flag; queue storage and output data hold no value until written.
`default_nettype none
module strict_priority_four_queue_dispatch_top
  import spqd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // call_class[1:0], caller_id[17:2], service_time[33:18]
  input  wire logic        s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // answered[0], answered_id[16:1],
                                          // answered_class[18:17], dropped[19]
);

  logic              in_acc;
  opcode_e           opcode;
  logic [ClassW-1:0] call_class;
  request_t          in_req;
  logic [SvcW-1:0]   busy_q, busy_d, busy_dec;
  logic              is_tick;
  pick_t             chain [NumClasses+1];
  logic [NumClasses-1:0] full;
  logic              dropped;
  logic              out_valid_q;
  logic [19:0]       out_data_q, out_data_d;

  assign opcode     = opcode_e'(s_axis_tuser);
  assign call_class = s_axis_tdata[1:0];
  assign in_req.id  = s_axis_tdata[17:2];
  assign in_req.svc = s_axis_tdata[33:18];

  // Output register frees its slot in the same cycle it is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = in_acc && (opcode == OP_TICK);

  // The server counts down one per tick and may dispatch once it reaches zero.
  assign busy_dec = (busy_q == '0) ? '0 : busy_q - 1'b1;

  always_comb begin
    chain[0]      = '0;
    chain[0].open = is_tick && (busy_dec == '0);
  end

  for (genvar c = 0; c < NumClasses; c++) begin : g_cell
    spqd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_cls_i (ClassW'(c)),
      .push_i     (in_acc && (opcode == OP_ARRIVAL) && (call_class == ClassW'(c))),
      .push_req_i (in_req),
      .pick_i     (chain[c]),
      .pick_o     (chain[c+1]),
      .full_o     (full[c])
    );
  end

  assign dropped = full[call_class];

  // Server timer update.
  always_comb begin
    busy_d = busy_q;
    if (is_tick) begin
      busy_d = chain[NumClasses].hit ? chain[NumClasses].req.svc : busy_dec;
    end
  end

  // Result word assembly.
  always_comb begin
    out_data_d = '0;
    if (opcode == OP_TICK) begin
      if (chain[NumClasses].hit) begin
        out_data_d[0]     = 1'b1;
        out_data_d[16:1]  = chain[NumClasses].req.id;
        out_data_d[18:17] = chain[NumClasses].cls;
      end
    end else begin
      out_data_d[19] = dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

endmodule
`default_nettype wire

// File: verif/tb_strict_priority_four_queue_dispatch_top.sv
// Self-checking testbench for the strict priority four queue dispatcher.
`timescale 1ns / 1ps
module tb_strict_priority_four_queue_dispatch_top;
  import spqd_pkg::*;

  localparam int RandomCalls = 1420;
  localparam int DrainTicks  = 300;

  // Handshake pacing of one stretch of the run.
  typedef enum logic [1:0] {
    PACE_STEADY,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  // One input word as the sender queues it.
  typedef struct packed {
    opcode_e           op;
    logic [ClassW-1:0] cls;
    logic [IdW-1:0]    id;
    logic [SvcW-1:0]   svc;
    pace_e             pace;
  } call_item_t;

  // One output word, unpacked.
  typedef struct packed {
    logic              answered;
    logic [IdW-1:0]    id;
    logic [ClassW-1:0] cls;
    logic              dropped;
  } dispatch_outcome_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  strict_priority_four_queue_dispatch_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the class queues and the server timer.
  request_t          class_fifo  [NumClasses][QueueDepth];
  logic [SlotW-1:0]  fifo_rd     [NumClasses] = '{default: '0};
  logic [SlotW-1:0]  fifo_wr     [NumClasses] = '{default: '0};
  logic [CountW-1:0] fifo_fill   [NumClasses] = '{default: '0};
  logic [SvcW-1:0]   server_busy = '0;

  call_item_t        call_backlog[$];
  dispatch_outcome_t dispatch_outcomes[$];
  call_item_t        on_wire;
  dispatch_outcome_t seen;
  pace_e             recv_pace   = PACE_STEADY;

  int words_sent     = 0;
  int words_returned = 0;
  int calls_answered = 0;
  int calls_dropped  = 0;
  int busy_ticks     = 0;
  int mismatch_count = 0;

  function automatic logic [SlotW-1:0] next_slot(logic [SlotW-1:0] s);
    return (s == SlotW'(QueueDepth - 1)) ? '0 : s + 1'b1;
  endfunction

  // Percentage of cycles one side holds off in the given pacing stretch.
  function automatic int idle_share(pace_e pace, bit recv_side);
    case (pace)
      PACE_SEND_GAPS:   return recv_side ? 0 : 76;
      PACE_RECV_STALLS: return recv_side ? 76 : 0;
      PACE_BOTH:        return 23;
      default:          return 0;
    endcase
  endfunction

  function automatic call_item_t make_call(opcode_e op, int cls, int id, int svc, pace_e pace);
    call_item_t c;
    c.op   = op;
    c.cls  = ClassW'(cls);
    c.id   = IdW'(id);
    c.svc  = SvcW'(svc);
    c.pace = pace;
    return c;
  endfunction

  // Advance the shadow dispatcher by one word and return the word it must answer.
  function automatic dispatch_outcome_t compute_dispatch_outcome(call_item_t call);
    dispatch_outcome_t res;
    logic [ClassW-1:0] k;
    res = '0;
    k = call.cls;
    if (call.op == OP_ARRIVAL) begin
      if (int'(k) >= NumClasses || fifo_fill[k] == CountW'(QueueDepth)) begin
        res.dropped = 1'b1;
        calls_dropped++;
      end else begin
        class_fifo[k][fifo_wr[k]] = '{id: call.id, svc: call.svc};
        fifo_wr[k] = next_slot(fifo_wr[k]);
        fifo_fill[k]++;
      end
    end else begin
      // The timer counts down first; a dispatch only happens once it reaches zero.
      if (server_busy != '0) server_busy--;
      if (server_busy != '0) begin
        busy_ticks++;
      end else begin
        for (int c = 0; c < NumClasses; c++) begin
          if (fifo_fill[c] != '0) begin
            res.answered = 1'b1;
            res.id       = class_fifo[c][fifo_rd[c]].id;
            res.cls      = ClassW'(c);
            server_busy  = class_fifo[c][fifo_rd[c]].svc;
            fifo_rd[c]   = next_slot(fifo_rd[c]);
            fifo_fill[c]--;
            calls_answered++;
            break;
          end
        end
      end
    end
    return res;
  endfunction

  // Sender: takes words from the backlog and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dispatch_outcomes.push_back(compute_dispatch_outcome(on_wire));
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (call_backlog.size() != 0 &&
            $urandom_range(99) >= idle_share(call_backlog[0].pace, 1'b0)) begin
          on_wire = call_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, on_wire.svc, on_wire.id, on_wire.cls};
          s_axis_tuser  <= on_wire.op;
          recv_pace     <= on_wire.pace;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every returned word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_returned++;
        seen.answered = m_axis_tdata[0];
        seen.id       = m_axis_tdata[16:1];
        seen.cls      = m_axis_tdata[18:17];
        seen.dropped  = m_axis_tdata[19];
        if (dispatch_outcomes.size() == 0) begin
          $error("unexpected output word %0h", m_axis_tdata);
          mismatch_count++;
        end else begin
          dispatch_outcome_t want;
          want = dispatch_outcomes.pop_front();
          if (seen.answered !== want.answered) begin
            $error("answered mismatch: expected %0d, got %0d", want.answered, seen.answered);
            mismatch_count++;
          end
          if (seen.id !== want.id) begin
            $error("answered_id mismatch: expected %0h, got %0h", want.id, seen.id);
            mismatch_count++;
          end
          if (seen.cls !== want.cls) begin
            $error("answered_class mismatch: expected %0d, got %0d", want.cls, seen.cls);
            mismatch_count++;
          end
          if (seen.dropped !== want.dropped) begin
            $error("dropped mismatch: expected %0d, got %0d", want.dropped, seen.dropped);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_share(recv_pace, 1'b1));
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int arrival_pct;
    int roll;
    int svc;
    arrival_pct = 50;

    // Tick on an empty dispatcher, with every payload bit set to show it is ignored.
    call_backlog.push_back(make_call(OP_TICK, 3, 'hFFFF, 'hFFFF, PACE_STEADY));
    // One call per class, lowest priority first, then ticks to drain them in
    // priority order while the server runs busy between dispatches.
    call_backlog.push_back(make_call(OP_ARRIVAL, 3, 'h0000, 0, PACE_STEADY));
    call_backlog.push_back(make_call(OP_ARRIVAL, 2, 'hFFFF, 1, PACE_STEADY));
    call_backlog.push_back(make_call(OP_ARRIVAL, 1, 'h1234, 2, PACE_STEADY));
    call_backlog.push_back(make_call(OP_ARRIVAL, 0, 'h0000, 0, PACE_STEADY));
    // Fill the lowest class to the brim; the last arrival overflows and is dropped.
    for (int i = 0; i < QueueDepth; i++)
      call_backlog.push_back(make_call(OP_ARRIVAL, 3, 'hA000 + i, i % 3, PACE_STEADY));
    for (int i = 0; i < 6; i++)
      call_backlog.push_back(make_call(OP_TICK, 0, 0, 0, PACE_STEADY));

    // Random traffic in bursts whose arrival rate swings between draining and overflowing.
    for (int i = 0; i < RandomCalls; i++) begin
      if (i % 40 == 0) arrival_pct = $urandom_range(25, 75);
      roll = $urandom_range(99);
      if (roll < 45) svc = 0;
      else if (roll < 85) svc = $urandom_range(1, 3);
      else svc = $urandom_range(4, 12);
      if ($urandom_range(99) < arrival_pct)
        call_backlog.push_back(make_call(OP_ARRIVAL, $urandom_range(3), $urandom_range(65535),
                                         svc, pace_e'(i * 4 / RandomCalls)));
      else
        call_backlog.push_back(make_call(OP_TICK, $urandom_range(3), $urandom_range(65535),
                                         $urandom_range(65535), pace_e'(i * 4 / RandomCalls)));
    end

    // Let the queues drain, then send calls with long service times, followed by ticks.
    for (int i = 0; i < DrainTicks; i++)
      call_backlog.push_back(make_call(OP_TICK, $urandom_range(3), $urandom_range(65535),
                                       $urandom_range(65535), PACE_STEADY));
    call_backlog.push_back(make_call(OP_ARRIVAL, 0, 'hFFFF, 'hFFFF, PACE_STEADY));
    call_backlog.push_back(make_call(OP_ARRIVAL, 3, 'h5A5A, 'h8000, PACE_STEADY));
    for (int i = 0; i < 4; i++)
      call_backlog.push_back(make_call(OP_TICK, 0, 0, 0, PACE_STEADY));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (call_backlog.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (dispatch_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words, %0d came back: %0d calls answered, %0d dropped,",
             words_sent, words_returned, calls_answered, calls_dropped);
    $display("%0d ticks with the server still busy, %0d field mismatches.",
             busy_ticks, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
